>>> design/gb5_pkg.sv
package gb5_pkg;

    localparam int DEFAULT_MAX_WIDTH = 512;

    localparam int PIX_W          = 8;
    localparam int ROW_W          = 12;
    localparam int OUT_COL_W      = 9;
    localparam int LINE_WIDTH_W   = 10;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam int LINE_WIDTH_RST   = 512;
    localparam int FRAME_HEIGHT_RST = 512;
    localparam int MAX_HEIGHT       = 4096;
    localparam int MIN_SIZE         = 5;

    localparam int LINES  = 4;
    localparam int TAPS   = 5;
    localparam int WORD_W = LINES * PIX_W;
    localparam int HSUM_W = 12;
    localparam int VSUM_W = 16;

    localparam logic [TAPS-1:0][2:0] BINOM = {3'd1, 3'd4, 3'd6, 3'd4, 3'd1};

    typedef struct packed {
        logic                 emit;
        logic [ROW_W-1:0]     row_out;
        logic [OUT_COL_W-1:0] col_out;
        logic                 last;
    } gb5_meta_t;

    // 1-4-6-4-1 weighted sum of five taps
    function automatic logic [VSUM_W-1:0] binom_sum(input logic [TAPS-1:0][HSUM_W-1:0] x);
        logic [VSUM_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            acc = acc + VSUM_W'(x[i]) * VSUM_W'(BINOM[i]);
        end
        return acc;
    endfunction

endpackage

>>> design/gb5_in_if.sv
interface gb5_in_if;
    import gb5_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink (input valid, input pixel_in, input frame_start, output ready);
endinterface

>>> design/gb5_out_if.sv
interface gb5_out_if;
    import gb5_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PIX_W-1:0]     pixel_out;
    logic [ROW_W-1:0]     out_row;
    logic [OUT_COL_W-1:0] out_col;
    logic                 frame_last;

    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink (input valid, input pixel_out, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

>>> design/gaussian_blur_5x5.sv
// channel   | dir | payload                                     | request when
// ----------+-----+---------------------------------------------+--------------------
// pix_in    | in  | pixel_in, frame_start                       | valid && ready
// pix_out   | out | pixel_out, out_row, out_col, frame_last     | valid && ready
// cfg       | in  | cfg_index, cfg_wdata                        | cfg_we
//
// one pixel per clock while pix_out is ready; results pass stages s1, s2, s3, out
// line stores live in one ram word per column, read on request, written when s1 moves
// rst_n resets counters, config, window and all valid flags; ram contents are not cleared
// each stage moves when the next one is empty or moving, so pix_in stays ready while
// a result waits, until the three inner stages are full
module gaussian_blur_5x5 #(
    parameter int MAX_WIDTH = gb5_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gb5_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gb5_pkg::CFG_DATA_W-1:0] cfg_wdata,
    gb5_in_if.sink                         pix_in,
    gb5_out_if.source                      pix_out
);
    import gb5_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic adv0, adv1, adv2, adv3;
    logic accept;

    logic [COL_W-1:0] pos_col;
    gb5_meta_t        pos_meta;

    logic             s1_valid_reg, s1_valid_next;
    gb5_meta_t        s1_meta_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             fwd_reg;
    logic [WORD_W-1:0] fwd_word_reg;

    logic      s2_valid_reg, s2_valid_next;
    gb5_meta_t s2_meta_reg;
    logic      s3_valid_reg, s3_valid_next;
    gb5_meta_t s3_meta_reg;

    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_pix_reg;
    gb5_meta_t        out_meta_reg;

    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] line_word;
    logic [WORD_W-1:0] wr_word;
    logic              ram_we;
    logic [TAPS-1:0][PIX_W-1:0] column;
    logic [PIX_W-1:0]  blur;

    assign adv3   = !out_valid_reg || pix_out.ready;
    assign adv2   = !s3_valid_reg || adv3;
    assign adv1   = !s2_valid_reg || adv2;
    assign adv0   = !s1_valid_reg || adv1;
    assign accept = pix_in.valid && adv0;

    assign pix_in.ready = adv0;

    gb5_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .frame_start (pix_in.frame_start),
        .col         (pos_col),
        .meta        (pos_meta)
    );

    // bypass covers a write and a read of the same column on one edge
    assign line_word = fwd_reg ? fwd_word_reg : ram_rdata;
    assign wr_word   = {line_word[WORD_W-PIX_W-1:0], s1_pix_reg};
    assign ram_we    = s1_valid_reg && adv1;

    gb5_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_col_reg),
        .wdata (wr_word),
        .re    (accept),
        .raddr (pos_col),
        .rdata (ram_rdata)
    );

    // oldest row first, the new pixel last
    always_comb
    begin
        for (int k = 0; k < LINES; k++)
        begin
            column[k] = line_word[(LINES-1-k)*PIX_W +: PIX_W];
        end
        column[TAPS-1] = s1_pix_reg;
    end

    gb5_kernel u_kernel (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (ram_we),
        .column_in (column),
        .hsum_en   (adv2 && s2_valid_reg),
        .blur      (blur)
    );

    assign s1_valid_next  = adv0 ? pix_in.valid : s1_valid_reg;
    assign s2_valid_next  = adv1 ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next  = adv2 ? s2_valid_reg : s3_valid_reg;
    assign out_valid_next = adv3 ? (s3_valid_reg && s3_meta_reg.emit) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                fwd_reg <= ram_we && (s1_col_reg == pos_col);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg  <= pos_meta;
            s1_pix_reg   <= pix_in.pixel_in;
            s1_col_reg   <= pos_col;
            fwd_word_reg <= wr_word;
        end
        if (adv1 && s1_valid_reg)
        begin
            s2_meta_reg <= s1_meta_reg;
        end
        if (adv2 && s2_valid_reg)
        begin
            s3_meta_reg <= s2_meta_reg;
        end
        if (adv3 && s3_valid_reg)
        begin
            out_pix_reg  <= blur;
            out_meta_reg <= s3_meta_reg;
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.pixel_out  = out_pix_reg;
    assign pix_out.out_row    = out_meta_reg.row_out;
    assign pix_out.out_col    = out_meta_reg.col_out;
    assign pix_out.frame_last = out_meta_reg.last;

    a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ram_we && (s1_col_reg == pos_col) |=> fwd_reg)
        else $error("same-column write not bypassed to next read");

    a_rdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !adv1 |=> $stable(ram_rdata))
        else $error("line data changed under a stalled stage");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_meta_reg.row_out >= ROW_W'(2)
                          && out_meta_reg.row_out <= ROW_W'(MAX_HEIGHT - 3))
        else $error("result row outside the interior of the frame");
endmodule

>>> design/gb5_ram.sv
module gb5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> design/gb5_pos.sv
module gb5_pos #(
    parameter int MAX_WIDTH = gb5_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gb5_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gb5_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            accept,
    input  logic                            frame_start,
    output logic [$clog2(MAX_WIDTH)-1:0]    col,
    output gb5_pkg::gb5_meta_t              meta
);
    import gb5_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int COL_LAST_RST =
        ((LINE_WIDTH_RST < MAX_WIDTH) ? LINE_WIDTH_RST : MAX_WIDTH) - 1;

    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [COL_W-1:0] col_last_reg, col_last_next;
    logic [ROW_W-1:0] row_last_reg, row_last_next;

    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col_m2;
    logic                      col_end;
    logic                      row_end;
    logic [LINE_WIDTH_W-1:0]   lw;
    logic [FRAME_HEIGHT_W-1:0] fh;

    assign col     = frame_start ? '0 : col_count_reg;
    assign row     = frame_start ? '0 : row_count_reg;
    assign col_end = col >= col_last_reg;
    assign row_end = row >= row_last_reg;
    assign col_m2  = col - COL_W'(2);

    assign meta.emit    = (row >= ROW_W'(4)) && (col >= COL_W'(4));
    assign meta.row_out = row - ROW_W'(2);
    assign meta.col_out = OUT_COL_W'(col_m2);
    assign meta.last    = row_end && col_end;

    assign lw = cfg_wdata[LINE_WIDTH_W-1:0];
    assign fh = cfg_wdata[FRAME_HEIGHT_W-1:0];

    // registers hold the clamped last column and last row
    always_comb
    begin
        col_last_next = col_last_reg;
        row_last_next = row_last_reg;
        if (cfg_we && cfg_index == REG_LINE_WIDTH)
        begin
            if (lw < LINE_WIDTH_W'(MIN_SIZE))
                col_last_next = COL_W'(MIN_SIZE - 1);
            else if (32'(lw) > 32'(MAX_WIDTH))
                col_last_next = COL_W'(MAX_WIDTH - 1);
            else
                col_last_next = COL_W'(lw - LINE_WIDTH_W'(1));
        end
        if (cfg_we && cfg_index == REG_FRAME_HEIGHT)
        begin
            if (fh < FRAME_HEIGHT_W'(MIN_SIZE))
                row_last_next = ROW_W'(MIN_SIZE - 1);
            else if (fh > FRAME_HEIGHT_W'(MAX_HEIGHT))
                row_last_next = ROW_W'(MAX_HEIGHT - 1);
            else
                row_last_next = ROW_W'(fh - FRAME_HEIGHT_W'(1));
        end
    end

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (col_end)
            begin
                col_count_next = '0;
                row_count_next = row_end ? '0 : row + ROW_W'(1);
            end
            else
            begin
                col_count_next = col + COL_W'(1);
                row_count_next = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            col_last_reg  <= COL_W'(COL_LAST_RST);
            row_last_reg  <= ROW_W'(FRAME_HEIGHT_RST - 1);
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            col_last_reg  <= col_last_next;
            row_last_reg  <= row_last_next;
        end
    end

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && meta.last |=> col_count_reg == '0 && row_count_reg == '0)
        else $error("counters did not wrap after last pixel of frame");

    a_width_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == REG_LINE_WIDTH |=> col_last_reg >= COL_W'(MIN_SIZE - 1))
        else $error("line width clamp below minimum");
endmodule

>>> design/gb5_kernel.sv
module gb5_kernel (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            shift_en,
    input  logic [gb5_pkg::TAPS-1:0][gb5_pkg::PIX_W-1:0]    column_in,
    input  logic                                            hsum_en,
    output logic [gb5_pkg::PIX_W-1:0]                       blur
);
    import gb5_pkg::*;

    logic [PIX_W-1:0]  win_reg  [TAPS][TAPS];
    logic [HSUM_W-1:0] hsum_reg [TAPS];
    logic [HSUM_W-1:0] hsum_next [TAPS];

    logic [TAPS-1:0][HSUM_W-1:0] vtaps;
    logic [VSUM_W-1:0]           vsum;

    // window shifts left, newest column enters on the right
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < TAPS; r++)
            begin
                for (int c = 0; c < TAPS; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (shift_en)
        begin
            for (int r = 0; r < TAPS; r++)
            begin
                for (int c = 0; c < TAPS - 1; c++)
                begin
                    win_reg[r][c] <= win_reg[r][c+1];
                end
                win_reg[r][TAPS-1] <= column_in[r];
            end
        end
    end

    always_comb
    begin
        logic [TAPS-1:0][HSUM_W-1:0] htaps;
        for (int r = 0; r < TAPS; r++)
        begin
            for (int c = 0; c < TAPS; c++)
            begin
                htaps[c] = HSUM_W'(win_reg[r][c]);
            end
            hsum_next[r] = HSUM_W'(binom_sum(htaps));
        end
    end

    always_ff @(posedge clk)
    begin
        if (hsum_en)
        begin
            for (int r = 0; r < TAPS; r++)
            begin
                hsum_reg[r] <= hsum_next[r];
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < TAPS; r++)
        begin
            vtaps[r] = hsum_reg[r];
        end
    end

    // kernel total is 256, so the top byte is the result
    assign vsum = binom_sum(vtaps);
    assign blur = vsum[VSUM_W-1 -: PIX_W];
endmodule
